### rtl/bse_pkg.sv
package bse_pkg;

  localparam int DEPTH      = 64;
  localparam int DATA_WIDTH = 32;
  localparam int ADDR_W     = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int CMD_W      = 3;
  localparam int POS_W      = 7;
  localparam int STAT_W     = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH    = 3'd0,
    CMD_POP     = 3'd1,
    CMD_REVERSE = 3'd2,
    CMD_DEDUPE  = 3'd3,
    CMD_READ    = 3'd4
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_RANGE = 2'd3
  } stat_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_TOP_ISSUE,
    S_TOP_TAKE,
    S_RD_TAKE,
    S_REV_RD_LO,
    S_REV_RD_HI,
    S_REV_WR_LO,
    S_REV_WR_HI,
    S_DD_RD_V,
    S_DD_LATCH_V,
    S_DD_SCAN,
    S_DD_CMP,
    S_DD_CP_RD,
    S_DD_CP_WR,
    S_DONE
  } state_t;

  // micro-operations issued by the controller to the datapath
  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_PUSH,
    OP_POP,
    OP_FAIL_EMPTY,
    OP_FAIL_FULL,
    OP_FAIL_RANGE,
    OP_RD_ISSUE,
    OP_RD_TAKE,
    OP_TOP_ISSUE,
    OP_TOP_TAKE,
    OP_REV_INIT,
    OP_REV_RD_LO,
    OP_REV_RD_HI,
    OP_REV_WR_LO,
    OP_REV_WR_HI,
    OP_DD_INIT,
    OP_DD_RD_V,
    OP_DD_LATCH_V,
    OP_DD_SCAN,
    OP_DD_NEXT_J,
    OP_DD_SKIP,
    OP_DD_WR,
    OP_DD_CP_INIT,
    OP_DD_CP_RD,
    OP_DD_CP_WR,
    OP_DD_COMMIT,
    OP_FINISH
  } dp_op_t;

  typedef struct packed {
    cmd_t cmd;
    logic full;
    logic empty;
    logic lt2;
    logic range_bad;
    logic rev_more;
    logic k_done;
    logic a_eq_kept;
    logic j_done;
    logic match;
  } dp_stat_t;

endpackage

### rtl/bse_ram.sv
module bse_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

### rtl/bse_dp.sv
module bse_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  bse_pkg::dp_op_t                     op,
  output bse_pkg::dp_stat_t                   st,
  input  logic [bse_pkg::CMD_W-1:0]           in_command,
  input  logic signed [bse_pkg::DATA_WIDTH-1:0] in_push_value,
  input  logic signed [bse_pkg::POS_W-1:0]    in_position,
  output logic                                out_valid,
  output logic signed [bse_pkg::DATA_WIDTH-1:0] out_data_out,
  output logic [bse_pkg::STAT_W-1:0]          out_status,
  output logic [bse_pkg::CNT_W-1:0]           out_depth_used,
  output logic signed [bse_pkg::DATA_WIDTH-1:0] out_top_value,
  output logic                                out_top_valid
);

  import bse_pkg::*;

  cmd_t                  cmd_r, cmd_nxt;
  logic [DATA_WIDTH-1:0] val_r, val_nxt;
  logic [POS_W-1:0]      pos_r, pos_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [DATA_WIDTH-1:0] top_r, top_nxt;
  logic [DATA_WIDTH-1:0] data_r, data_nxt;
  stat_t                 status_r, status_nxt;
  logic [CNT_W-1:0]      idx_a_r, idx_a_nxt;
  logic [CNT_W-1:0]      idx_b_r, idx_b_nxt;
  logic [CNT_W-1:0]      kept_r, kept_nxt;
  logic [DATA_WIDTH-1:0] hold_r, hold_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic [DATA_WIDTH-1:0] out_data_r, out_data_nxt;
  stat_t                 out_status_r, out_status_nxt;
  logic [CNT_W-1:0]      out_depth_r, out_depth_nxt;
  logic [DATA_WIDTH-1:0] out_top_r, out_top_nxt;
  logic                  out_top_valid_r, out_top_valid_nxt;

  logic                  st_we, sc_we;
  logic [ADDR_W-1:0]     st_waddr, st_raddr, sc_waddr, sc_raddr;
  logic [DATA_WIDTH-1:0] st_wdata, st_rdata, sc_wdata, sc_rdata;

  logic [CNT_W-1:0]      cnt_dec, dd_src, cp_src, rd_n, rd_off;
  logic [ADDR_W-1:0]     rd_addr;

  assign cnt_dec = cnt_r - CNT_W'(1);
  assign dd_src  = cnt_dec - idx_a_r;
  assign cp_src  = kept_r - CNT_W'(1) - idx_a_r;

  // negative position counts from the bottom: -1 -> 0, -2 -> 1, ...
  assign rd_n    = pos_r[POS_W-1] ? CNT_W'({1'b0, ~pos_r[POS_W-2:0]})
                                  : CNT_W'(pos_r[POS_W-2:0]);
  assign rd_off  = pos_r[POS_W-1] ? rd_n : (cnt_dec - rd_n);
  assign rd_addr = rd_off[ADDR_W-1:0];

  assign st.cmd       = cmd_r;
  assign st.full      = (cnt_r == CNT_W'(DEPTH));
  assign st.empty     = (cnt_r == '0);
  assign st.lt2       = (cnt_r < CNT_W'(2));
  assign st.range_bad = !(rd_n < cnt_r);
  assign st.rev_more  = ((idx_a_r + CNT_W'(2)) < idx_b_r);
  assign st.k_done    = (idx_a_r == cnt_r);
  assign st.a_eq_kept = (idx_a_r == kept_r);
  assign st.j_done    = (idx_b_r == kept_r);
  assign st.match     = (sc_rdata == hold_r);

  bse_ram #(.WIDTH(DATA_WIDTH), .DEPTH(DEPTH)) u_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  // scratch holds the kept words, top first, during dedupe
  bse_ram #(.WIDTH(DATA_WIDTH), .DEPTH(DEPTH)) u_scratch (
    .clk   (clk),
    .we    (sc_we),
    .waddr (sc_waddr),
    .wdata (sc_wdata),
    .raddr (sc_raddr),
    .rdata (sc_rdata)
  );

  always_comb begin
    cmd_nxt           = cmd_r;
    val_nxt           = val_r;
    pos_nxt           = pos_r;
    cnt_nxt           = cnt_r;
    top_nxt           = top_r;
    data_nxt          = data_r;
    status_nxt        = status_r;
    idx_a_nxt         = idx_a_r;
    idx_b_nxt         = idx_b_r;
    kept_nxt          = kept_r;
    hold_nxt          = hold_r;
    out_valid_nxt     = 1'b0;
    out_data_nxt      = out_data_r;
    out_status_nxt    = out_status_r;
    out_depth_nxt     = out_depth_r;
    out_top_nxt       = out_top_r;
    out_top_valid_nxt = out_top_valid_r;
    st_we    = 1'b0;
    st_waddr = '0;
    st_wdata = '0;
    st_raddr = '0;
    sc_we    = 1'b0;
    sc_waddr = '0;
    sc_wdata = '0;
    sc_raddr = '0;
    unique case (op)
      OP_NONE: begin
      end
      OP_LOAD: begin
        cmd_nxt    = cmd_t'(in_command);
        val_nxt    = in_push_value;
        pos_nxt    = in_position;
        data_nxt   = '0;
        status_nxt = ST_OK;
      end
      OP_PUSH: begin
        st_we    = 1'b1;
        st_waddr = cnt_r[ADDR_W-1:0];
        st_wdata = val_r;
        cnt_nxt  = cnt_r + CNT_W'(1);
        top_nxt  = val_r;
      end
      OP_POP: begin
        cnt_nxt  = cnt_dec;
        data_nxt = top_r;
      end
      OP_FAIL_EMPTY: status_nxt = ST_EMPTY;
      OP_FAIL_FULL:  status_nxt = ST_FULL;
      OP_FAIL_RANGE: status_nxt = ST_RANGE;
      OP_RD_ISSUE:   st_raddr   = rd_addr;
      OP_RD_TAKE:    data_nxt   = st_rdata;
      OP_TOP_ISSUE:  st_raddr   = cnt_dec[ADDR_W-1:0];
      OP_TOP_TAKE:   top_nxt    = (cnt_r == '0) ? '0 : st_rdata;
      OP_REV_INIT: begin
        idx_a_nxt = '0;
        idx_b_nxt = cnt_dec;
      end
      OP_REV_RD_LO: st_raddr = idx_a_r[ADDR_W-1:0];
      OP_REV_RD_HI: begin
        st_raddr = idx_b_r[ADDR_W-1:0];
        hold_nxt = st_rdata;
      end
      OP_REV_WR_LO: begin
        st_we    = 1'b1;
        st_waddr = idx_a_r[ADDR_W-1:0];
        st_wdata = st_rdata;
      end
      OP_REV_WR_HI: begin
        st_we     = 1'b1;
        st_waddr  = idx_b_r[ADDR_W-1:0];
        st_wdata  = hold_r;
        idx_a_nxt = idx_a_r + CNT_W'(1);
        idx_b_nxt = idx_b_r - CNT_W'(1);
      end
      OP_DD_INIT: begin
        idx_a_nxt = '0;
        kept_nxt  = '0;
      end
      OP_DD_RD_V: begin
        st_raddr  = dd_src[ADDR_W-1:0];
        idx_b_nxt = '0;
      end
      OP_DD_LATCH_V: hold_nxt  = st_rdata;
      OP_DD_SCAN:    sc_raddr  = idx_b_r[ADDR_W-1:0];
      OP_DD_NEXT_J:  idx_b_nxt = idx_b_r + CNT_W'(1);
      OP_DD_SKIP:    idx_a_nxt = idx_a_r + CNT_W'(1);
      OP_DD_WR: begin
        sc_we     = 1'b1;
        sc_waddr  = kept_r[ADDR_W-1:0];
        sc_wdata  = hold_r;
        kept_nxt  = kept_r + CNT_W'(1);
        idx_a_nxt = idx_a_r + CNT_W'(1);
      end
      OP_DD_CP_INIT: idx_a_nxt = '0;
      OP_DD_CP_RD:   sc_raddr  = cp_src[ADDR_W-1:0];
      OP_DD_CP_WR: begin
        st_we     = 1'b1;
        st_waddr  = idx_a_r[ADDR_W-1:0];
        st_wdata  = sc_rdata;
        idx_a_nxt = idx_a_r + CNT_W'(1);
      end
      // top entry survives dedupe, so top_r needs no reload
      OP_DD_COMMIT: cnt_nxt = kept_r;
      OP_FINISH: begin
        out_valid_nxt     = 1'b1;
        out_data_nxt      = data_r;
        out_status_nxt    = status_r;
        out_depth_nxt     = cnt_r;
        out_top_nxt       = (cnt_r == '0) ? '0 : top_r;
        out_top_valid_nxt = (cnt_r != '0);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      top_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      top_r       <= top_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r           <= cmd_nxt;
    val_r           <= val_nxt;
    pos_r           <= pos_nxt;
    data_r          <= data_nxt;
    status_r        <= status_nxt;
    idx_a_r         <= idx_a_nxt;
    idx_b_r         <= idx_b_nxt;
    kept_r          <= kept_nxt;
    hold_r          <= hold_nxt;
    out_data_r      <= out_data_nxt;
    out_status_r    <= out_status_nxt;
    out_depth_r     <= out_depth_nxt;
    out_top_r       <= out_top_nxt;
    out_top_valid_r <= out_top_valid_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_data_out   = out_data_r;
  assign out_status     = out_status_r;
  assign out_depth_used = out_depth_r;
  assign out_top_value  = out_top_r;
  assign out_top_valid  = out_top_valid_r;

endmodule

### rtl/bse_ctrl.sv
module bse_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  bse_pkg::dp_stat_t st,
  output bse_pkg::dp_op_t   op
);

  import bse_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (st.cmd)
          CMD_PUSH:    state_nxt = S_DONE;
          CMD_POP:     state_nxt = st.empty ? S_DONE : S_TOP_ISSUE;
          CMD_REVERSE: state_nxt = st.lt2 ? S_DONE : S_REV_RD_LO;
          CMD_DEDUPE:  state_nxt = S_DD_RD_V;
          CMD_READ:    state_nxt = st.range_bad ? S_DONE : S_RD_TAKE;
          default:     state_nxt = S_DONE;
        endcase
      end
      S_TOP_ISSUE:  state_nxt = S_TOP_TAKE;
      S_TOP_TAKE:   state_nxt = S_DONE;
      S_RD_TAKE:    state_nxt = S_DONE;
      S_REV_RD_LO:  state_nxt = S_REV_RD_HI;
      S_REV_RD_HI:  state_nxt = S_REV_WR_LO;
      S_REV_WR_LO:  state_nxt = S_REV_WR_HI;
      S_REV_WR_HI:  state_nxt = st.rev_more ? S_REV_RD_LO : S_TOP_ISSUE;
      S_DD_RD_V:    state_nxt = st.k_done ? S_DD_CP_RD : S_DD_LATCH_V;
      S_DD_LATCH_V: state_nxt = S_DD_SCAN;
      S_DD_SCAN:    state_nxt = st.j_done ? S_DD_RD_V : S_DD_CMP;
      S_DD_CMP:     state_nxt = st.match ? S_DD_RD_V : S_DD_SCAN;
      S_DD_CP_RD:   state_nxt = st.a_eq_kept ? S_DONE : S_DD_CP_WR;
      S_DD_CP_WR:   state_nxt = S_DD_CP_RD;
      S_DONE:       state_nxt = S_IDLE;
      default:      state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    op = OP_NONE;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          op = OP_LOAD;
        end
      end
      S_DISPATCH: begin
        unique case (st.cmd)
          CMD_PUSH:    op = st.full ? OP_FAIL_FULL : OP_PUSH;
          CMD_POP:     op = st.empty ? OP_FAIL_EMPTY : OP_POP;
          CMD_REVERSE: op = st.lt2 ? OP_NONE : OP_REV_INIT;
          CMD_DEDUPE:  op = OP_DD_INIT;
          CMD_READ:    op = st.range_bad ? OP_FAIL_RANGE : OP_RD_ISSUE;
          default:     op = OP_NONE;
        endcase
      end
      S_TOP_ISSUE:  op = OP_TOP_ISSUE;
      S_TOP_TAKE:   op = OP_TOP_TAKE;
      S_RD_TAKE:    op = OP_RD_TAKE;
      S_REV_RD_LO:  op = OP_REV_RD_LO;
      S_REV_RD_HI:  op = OP_REV_RD_HI;
      S_REV_WR_LO:  op = OP_REV_WR_LO;
      S_REV_WR_HI:  op = OP_REV_WR_HI;
      S_DD_RD_V:    op = st.k_done ? OP_DD_CP_INIT : OP_DD_RD_V;
      S_DD_LATCH_V: op = OP_DD_LATCH_V;
      S_DD_SCAN:    op = st.j_done ? OP_DD_WR : OP_DD_SCAN;
      S_DD_CMP:     op = st.match ? OP_DD_SKIP : OP_DD_NEXT_J;
      S_DD_CP_RD:   op = st.a_eq_kept ? OP_DD_COMMIT : OP_DD_CP_RD;
      S_DD_CP_WR:   op = OP_DD_CP_WR;
      S_DONE:       op = OP_FINISH;
      default:      op = OP_NONE;
    endcase
  end

endmodule

### rtl/bounded_stack_engine.sv
// Result strobe follows the dispatch and finish states for push, failed ops, unused codes and
// reverse of fewer than two entries; read adds a take state, pop a top reload (issue, take).
// Reverse of N >= 2 entries: floor(N/2) swaps (read lo, read hi, write lo, write hi), then
// a top reload. Dedupe: each entry, top first, is checked against the K kept ones in scratch.
// A new transaction can be taken in the strobe cycle but never while busy, so none overlap.
// Synchronous active-low reset empties the stack; RAM contents are left as is.
module bounded_stack_engine (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  output logic                                  busy,
  input  logic [bse_pkg::CMD_W-1:0]             in_command,
  input  logic signed [bse_pkg::DATA_WIDTH-1:0] in_push_value,
  input  logic signed [bse_pkg::POS_W-1:0]      in_position,
  output logic                                  out_valid,
  output logic signed [bse_pkg::DATA_WIDTH-1:0] out_data_out,
  output logic [bse_pkg::STAT_W-1:0]            out_status,
  output logic [bse_pkg::CNT_W-1:0]             out_depth_used,
  output logic signed [bse_pkg::DATA_WIDTH-1:0] out_top_value,
  output logic                                  out_top_valid
);

  import bse_pkg::*;

  dp_op_t   op;
  dp_stat_t st;

  bse_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .st    (st),
    .op    (op)
  );

  bse_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .op             (op),
    .st             (st),
    .in_command     (in_command),
    .in_push_value  (in_push_value),
    .in_position    (in_position),
    .out_valid      (out_valid),
    .out_data_out   (out_data_out),
    .out_status     (out_status),
    .out_depth_used (out_depth_used),
    .out_top_value  (out_top_value),
    .out_top_valid  (out_top_valid)
  );

endmodule

### rtl/bse_checker.sv
module bse_checker (
  input logic                                  clk,
  input logic                                  rst_n,
  input logic                                  start,
  input logic                                  busy,
  input logic                                  out_valid,
  input logic signed [bse_pkg::DATA_WIDTH-1:0] out_data_out,
  input logic [bse_pkg::STAT_W-1:0]            out_status,
  input logic [bse_pkg::CNT_W-1:0]             out_depth_used,
  input logic signed [bse_pkg::DATA_WIDTH-1:0] out_top_value,
  input logic                                  out_top_valid
);

  import bse_pkg::*;

  a_top_valid_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_top_valid == (out_depth_used != '0)))
    else $error("top_valid disagrees with depth");

  a_empty_top_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_top_valid) |-> (out_top_value == '0))
    else $error("top value nonzero on empty stack");

  a_full_depth: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_FULL) |-> (out_depth_used == DEPTH))
    else $error("push-on-full reported below capacity");

  a_fail_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_OK) |-> (out_data_out == '0))
    else $error("failed transaction returned data");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy && !out_valid))
    else $error("accepted transaction did not raise busy");

endmodule

bind bounded_stack_engine bse_checker u_bse_checker (.*);
